### hdl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

  // Register map (index = byte address / 4)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RLE    = 2'd2;
  localparam logic [1:0] REG_BPP    = 2'd3;

  localparam int unsigned PADDR_W = 4;

  // Packet header fields
  localparam int unsigned HDR_RUN_BIT = 7;
  localparam logic [7:0]  MAX_PACKET  = 8'd128;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Decoupling queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Front-end packet phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_PIXEL  = 2'b10
  } phase_t;

  // Work entry handed from front to back
  typedef struct packed {
    logic       load;    // start a new image if nothing is owed
    logic       pixel;   // entry carries a pixel descriptor
    logic [7:0] rep;     // requested repeat, 1..128
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } entry_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic        rle;      // packets vs. raw pixels
    logic        pix4;     // four-byte pixels
    logic [31:0] size;     // pixels per image, registered product
  } cfg_t;

endpackage

### hdl/tgarle_front.sv
// Front end: takes stream bytes, tracks packets and assembles pixels into work entries.
module tgarle_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  tgarle_pkg::cfg_t     cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output tgarle_pkg::entry_t   q_data
);

  tgarle_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]         bpos_r, bpos_nxt;
  logic               is_run_r, is_run_nxt;
  logic [7:0]         left_r, left_nxt;
  logic [23:0]        colour_r, colour_nxt;

  logic               accept;
  logic [1:0]         last_pos;
  logic               g_done;
  logic [23:0]        g_colour;
  logic [7:0]         g_alpha;
  logic [7:0]         left_fix;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // Byte gathering into the current pixel
  assign last_pos = cfg.pix4 ? 2'd3 : 2'd2;
  assign g_done   = (bpos_r >= last_pos);
  assign g_alpha  = cfg.pix4 ? in_byte : tgarle_pkg::ALPHA_OPAQUE;

  always_comb begin
    g_colour = colour_r;
    if (g_done) begin
      if (!cfg.pix4) begin
        g_colour[23:16] = in_byte;
      end
    end else begin
      case (bpos_r)
        2'd0:    g_colour[7:0]   = in_byte;
        2'd1:    g_colour[15:8]  = in_byte;
        2'd2:    g_colour[23:16] = in_byte;
        default: g_colour        = colour_r;
      endcase
    end
  end

  // Out-of-range packet count acts as one
  assign left_fix = (left_r == 8'd0 || left_r > tgarle_pkg::MAX_PACKET) ? 8'd1 : left_r;

  // Packet state and entry generation
  always_comb begin
    phase_nxt    = phase_r;
    bpos_nxt     = bpos_r;
    is_run_nxt   = is_run_r;
    left_nxt     = left_r;
    colour_nxt   = colour_r;
    q_push       = 1'b0;
    q_data.load  = 1'b0;
    q_data.pixel = 1'b0;
    q_data.rep   = 8'd1;
    q_data.blue  = g_colour[7:0];
    q_data.green = g_colour[15:8];
    q_data.red   = g_colour[23:16];
    q_data.alpha = g_alpha;

    if (accept) begin
      if (!cfg.rle) begin
        // raw pixels
        colour_nxt = g_colour;
        bpos_nxt   = g_done ? 2'd0 : bpos_r + 2'd1;
        if (g_done) begin
          q_push       = 1'b1;
          q_data.load  = 1'b1;
          q_data.pixel = 1'b1;
        end
      end else if (phase_r == tgarle_pkg::PH_HEADER) begin
        // packet header
        q_push     = 1'b1;
        q_data.load = 1'b1;
        is_run_nxt = in_byte[tgarle_pkg::HDR_RUN_BIT];
        left_nxt   = {1'b0, in_byte[6:0]} + 8'd1;
        bpos_nxt   = 2'd0;
        phase_nxt  = tgarle_pkg::PH_PIXEL;
      end else begin
        // pixel bytes of a packet
        colour_nxt = g_colour;
        bpos_nxt   = g_done ? 2'd0 : bpos_r + 2'd1;
        if (g_done) begin
          q_push       = 1'b1;
          q_data.pixel = 1'b1;
          if (is_run_r) begin
            q_data.rep = left_fix;
            left_nxt   = 8'd0;
            phase_nxt  = tgarle_pkg::PH_HEADER;
          end else begin
            left_nxt = left_fix - 8'd1;
            if (left_fix == 8'd1) begin
              phase_nxt = tgarle_pkg::PH_HEADER;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tgarle_pkg::PH_HEADER;
      bpos_r   <= 2'd0;
      is_run_r <= 1'b0;
      left_r   <= 8'd0;
      colour_r <= 24'd0;
    end else begin
      phase_r  <= phase_nxt;
      bpos_r   <= bpos_nxt;
      is_run_r <= is_run_nxt;
      left_r   <= left_nxt;
      colour_r <= colour_nxt;
    end
  end

endmodule

### hdl/tgarle_queue.sv
// Short register queue decoupling the front end from the back end.
module tgarle_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tgarle_pkg::entry_t push_data,
  input  logic               pop,
  output tgarle_pkg::entry_t head,
  output logic               full,
  output logic               empty
);

  tgarle_pkg::entry_t                  slot_r [tgarle_pkg::QDEPTH];
  logic [tgarle_pkg::QPTR_W-1:0]       wr_r, wr_nxt;
  logic [tgarle_pkg::QPTR_W-1:0]       rd_r, rd_nxt;
  logic [tgarle_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                do_push;
  logic                                do_pop;

  assign full    = (cnt_r == tgarle_pkg::QCNT_W'(tgarle_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slot_r[rd_r];

  // Pointer and occupancy update
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

### hdl/tgarle_back.sv
// Back end: counts image pixels, clips runs and drives the output register.
module tgarle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tgarle_pkg::cfg_t   cfg,
  input  logic               q_empty,
  input  tgarle_pkg::entry_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red,
  output logic [7:0]         out_alpha,
  output logic [7:0]         out_repeat_res,
  output logic               out_image_last
);

  logic [31:0] owed_r, owed_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  blue_r, green_r, red_r, alpha_r, rep_r;
  logic        last_r;

  logic [31:0] base;
  logic        emits;
  logic        clip;
  logic [7:0]  rep_out;

  assign q_pop = ~q_empty & (~ov_r | ~out_stall);

  // Pixel accounting for the head entry
  assign base    = (q_head.load && owed_r == 32'd0) ? cfg.size : owed_r;
  assign emits   = q_head.pixel & (base != 32'd0);
  assign clip    = (base <= {24'd0, q_head.rep});
  assign rep_out = clip ? base[7:0] : q_head.rep;

  always_comb begin
    owed_nxt = owed_r;
    ov_nxt   = ov_r & out_stall;
    if (q_pop) begin
      owed_nxt = base;
      if (emits) begin
        owed_nxt = clip ? 32'd0 : base - {24'd0, q_head.rep};
        ov_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= 32'd0;
      ov_r   <= 1'b0;
    end else begin
      owed_r <= owed_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (q_pop && emits) begin
      blue_r  <= q_head.blue;
      green_r <= q_head.green;
      red_r   <= q_head.red;
      alpha_r <= q_head.alpha;
      rep_r   <= rep_out;
      last_r  <= clip;
    end
  end

  assign out_valid      = ov_r;
  assign out_blue       = blue_r;
  assign out_green      = green_r;
  assign out_red        = red_r;
  assign out_alpha      = alpha_r;
  assign out_repeat_res = rep_r;
  assign out_image_last = last_r;

endmodule

### hdl/tga_rle_pixel_decoder_core.sv
// Top level of the TGA run-length pixel decoder: register file, front, queue and back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------------
//  in       | in        | in_valid / in_stall  | in_byte
//  out      | out       | out_valid / out_stall| out_blue/green/red/alpha/repeat_res/image_last
//  config   | in        | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// One byte is taken every cycle while the 4-entry queue has room; the pixel that a byte
// completes passes through a queue slot and then the back output register before it leaves as a beat.
// The queue and the output register let input and output stall independently.
// Reset is synchronous (rst_n low): packet state, pixel count and queue are cleared,
// registers return to width 1, height 1, RLE on, 3 bytes per pixel.
module tga_rle_pixel_decoder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_alpha,
  output logic [7:0]                      out_repeat_res,
  output logic                            out_image_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tgarle_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [15:0]        width_r;
  logic [15:0]        height_r;
  logic               rle_r;
  logic [2:0]         bpp_r;
  logic [31:0]        size_r;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [15:0]        w_eff;
  logic [15:0]        h_eff;
  tgarle_pkg::cfg_t   cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  tgarle_pkg::entry_t q_wdata;
  tgarle_pkg::entry_t q_head;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
      rle_r    <= 1'b1;
      bpp_r    <= 3'd3;
    end else if (wr_en) begin
      case (reg_idx)
        tgarle_pkg::REG_WIDTH:  width_r  <= pwdata[15:0];
        tgarle_pkg::REG_HEIGHT: height_r <= pwdata[15:0];
        tgarle_pkg::REG_RLE:    rle_r    <= pwdata[0];
        tgarle_pkg::REG_BPP:    bpp_r    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tgarle_pkg::REG_WIDTH:  prdata = {16'd0, width_r};
      tgarle_pkg::REG_HEIGHT: prdata = {16'd0, height_r};
      tgarle_pkg::REG_RLE:    prdata = {31'd0, rle_r};
      tgarle_pkg::REG_BPP:    prdata = {29'd0, bpp_r};
      default:                prdata = 32'd0;
    endcase
  end

  // Image size, zero dimension acts as one; registered product
  assign w_eff = (width_r == 16'd0) ? 16'd1 : width_r;
  assign h_eff = (height_r == 16'd0) ? 16'd1 : height_r;

  always_ff @(posedge clk) begin
    size_r <= w_eff * h_eff;
  end

  assign cfg.rle  = rle_r;
  assign cfg.pix4 = (bpp_r >= 3'd4);
  assign cfg.size = size_r;

  tgarle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  tgarle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tgarle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_alpha      (out_alpha),
    .out_repeat_res (out_repeat_res),
    .out_image_last (out_image_last)
  );

endmodule
